>>> hw/rtl/ppt_pkg.sv
// Shared types and constants for the point-in-polygon test unit.
// No dependencies; imported by every module of the block.
package ppt_pkg;

    // Vertices needed before a polygon counts as non-degenerate
    localparam logic [1:0] MIN_VERTICES = 2'd3;

    // Edge queue depth between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Per-edge control carried alongside the coordinates
    typedef struct packed {
        logic closing;  // closing edge of a polygon; result goes out after it
        logic degen;    // polygon had fewer than three vertices
    } ppt_flags_t;

    localparam int FLAGS_WIDTH = $bits(ppt_flags_t);

endpackage

>>> hw/rtl/ppt_front.sv
// Front end: accepts vertex words, holds first/previous vertex and query point,
// and issues one edge job per edge. Depends on ppt_pkg.
module ppt_front #(
    parameter int COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_WIDTH-1:0] vertex_x,
    input  logic [COORD_WIDTH-1:0] vertex_y,
    input  logic [COORD_WIDTH-1:0] query_x,
    input  logic [COORD_WIDTH-1:0] query_y,
    input  logic                   last,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [COORD_WIDTH-1:0] xi,
    output logic [COORD_WIDTH-1:0] yi,
    output logic [COORD_WIDTH-1:0] xj,
    output logic [COORD_WIDTH-1:0] yj,
    output logic [COORD_WIDTH-1:0] px,
    output logic [COORD_WIDTH-1:0] py,
    output ppt_pkg::ppt_flags_t    flags
);
    import ppt_pkg::*;

    logic [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic [1:0]             count_reg, count_next;
    logic                   pending_reg, pending_next;

    logic accept;
    logic push_edge;
    logic push_close;

    // Closing edge is issued after the last vertex, once the queue is not full
    assign in_stall   = q_full || pending_reg;
    assign accept     = in_valid && !in_stall;
    assign push_edge  = accept && (count_reg != 2'd0);
    assign push_close = pending_reg && !q_full;
    assign q_push     = push_edge || push_close;

    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg;
        if (push_close)
        begin
            count_next   = 2'd0;
            pending_next = 1'b0;
        end
        else if (accept)
        begin
            if (count_reg != MIN_VERTICES)
                count_next = count_reg + 2'd1;
            pending_next = last;
        end
    end

    always_comb
    begin
        if (pending_reg)
        begin
            xi = first_x_reg;
            yi = first_y_reg;
        end
        else
        begin
            xi = vertex_x;
            yi = vertex_y;
        end
        xj            = prev_x_reg;
        yj            = prev_y_reg;
        px            = qx_reg;
        py            = qy_reg;
        flags.closing = pending_reg;
        flags.degen   = (count_reg != MIN_VERTICES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            pending_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_x_reg <= vertex_x;
            prev_y_reg <= vertex_y;
            if (count_reg == 2'd0)
            begin
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
                qx_reg      <= query_x;
                qy_reg      <= query_y;
            end
        end
    end

endmodule

>>> hw/rtl/ppt_queue.sv
// Short FIFO of edge jobs between the front and the back.
// Depends on ppt_pkg for its depth.
module ppt_queue #(
    parameter int DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output logic [DATA_WIDTH-1:0] rd_data
);
    import ppt_pkg::*;

    localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_WIDTH-1:0]  fill_reg, fill_next;
    logic                  do_push, do_pop;

    assign full    = (fill_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> hw/rtl/ppt_back.sv
// Back end: three-stage edge crossing test (differences, cross products,
// compare), parity accumulation and the result register. Depends on ppt_pkg.
module ppt_back #(
    parameter int COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic [COORD_WIDTH-1:0] xi,
    input  logic [COORD_WIDTH-1:0] yi,
    input  logic [COORD_WIDTH-1:0] xj,
    input  logic [COORD_WIDTH-1:0] yj,
    input  logic [COORD_WIDTH-1:0] px,
    input  logic [COORD_WIDTH-1:0] py,
    input  ppt_pkg::ppt_flags_t    flags,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   inside_res,
    output logic                   degenerate
);
    import ppt_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic enable;

    // stage 1: differences
    logic                 s1_valid_reg;
    logic signed [DW-1:0] dxq_reg, dy_reg, dxe_reg, dyq_reg;
    logic                 s1_straddle_reg, s1_dypos_reg;
    ppt_flags_t           s1_flags_reg;

    // stage 2: cross products
    logic                 s2_valid_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;
    logic                 s2_straddle_reg, s2_dypos_reg;
    ppt_flags_t           s2_flags_reg;

    // stage 3: compare, parity, result
    logic crossing;
    logic parity_reg, parity_next;
    logic out_valid_reg;
    logic inside_reg, degen_reg;

    logic signed [DW-1:0] sxi, syi, sxj, syj, spx, spy;

    assign enable = !out_valid_reg || !out_stall;
    assign q_pop  = enable && !q_empty;

    always_comb
    begin
        sxi = {xi[COORD_WIDTH-1], xi};
        syi = {yi[COORD_WIDTH-1], yi};
        sxj = {xj[COORD_WIDTH-1], xj};
        syj = {yj[COORD_WIDTH-1], yj};
        spx = {px[COORD_WIDTH-1], px};
        spy = {py[COORD_WIDTH-1], py};
    end

    // Crossing: qx < xi + (xj-xi)(qy-yi)/(yj-yi), cross-multiplied by dy
    always_comb
    begin
        if (s2_dypos_reg)
            crossing = s2_straddle_reg && (lhs_reg < rhs_reg);
        else
            crossing = s2_straddle_reg && (rhs_reg < lhs_reg);
        if (s2_flags_reg.closing)
            parity_next = 1'b0;
        else
            parity_next = parity_reg ^ crossing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_flags_reg.closing;
            if (s2_valid_reg)
                parity_reg <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            dxq_reg         <= spx - sxi;
            dy_reg          <= syj - syi;
            dxe_reg         <= sxj - sxi;
            dyq_reg         <= spy - syi;
            s1_straddle_reg <= (syi > spy) != (syj > spy);
            s1_dypos_reg    <= (syj > syi);
            s1_flags_reg    <= flags;

            lhs_reg         <= PW'(dxq_reg) * PW'(dy_reg);
            rhs_reg         <= PW'(dxe_reg) * PW'(dyq_reg);
            s2_straddle_reg <= s1_straddle_reg;
            s2_dypos_reg    <= s1_dypos_reg;
            s2_flags_reg    <= s1_flags_reg;

            if (s2_valid_reg && s2_flags_reg.closing)
            begin
                inside_reg <= !s2_flags_reg.degen && (parity_reg ^ crossing);
                degen_reg  <= s2_flags_reg.degen;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;

endmodule

>>> hw/rtl/point_in_polygon_test_unit.sv
// Top level of the even-odd point-in-polygon test unit.
// Depends on ppt_pkg, ppt_front, ppt_queue and ppt_back.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | vertex_x, vertex_y, query_x, query_y, last
//  output  | out_valid/ out_stall | inside_res, degenerate
//
// One vertex word per cycle while the edge queue is not full; after a word with
// last set, input stalls while the front issues the closing edge to the queue.
// A result is valid after its closing edge passes from the queue through
// the three back stages (differences, cross products, compare).
// Reset clears counts, parity and valids; coordinates are not reset.
// in_stall rises when the edge queue is full and in the cycle after a last word;
// out_stall freezes the back end while out_valid is high.
module point_in_polygon_test_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_WIDTH-1:0] vertex_x,
    input  logic [COORD_WIDTH-1:0] vertex_y,
    input  logic [COORD_WIDTH-1:0] query_x,
    input  logic [COORD_WIDTH-1:0] query_y,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   inside_res,
    output logic                   degenerate
);
    import ppt_pkg::*;

    localparam int JOB_WIDTH = 6 * COORD_WIDTH + FLAGS_WIDTH;

    logic                   q_full, q_empty, q_push, q_pop;
    logic [COORD_WIDTH-1:0] f_xi, f_yi, f_xj, f_yj, f_px, f_py;
    logic [COORD_WIDTH-1:0] b_xi, b_yi, b_xj, b_yj, b_px, b_py;
    ppt_flags_t             f_flags, b_flags;
    logic [JOB_WIDTH-1:0]   wr_job, rd_job;

    ppt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .query_x  (query_x),
        .query_y  (query_y),
        .last     (last),
        .q_full   (q_full),
        .q_push   (q_push),
        .xi       (f_xi),
        .yi       (f_yi),
        .xj       (f_xj),
        .yj       (f_yj),
        .px       (f_px),
        .py       (f_py),
        .flags    (f_flags)
    );

    assign wr_job = {f_flags, f_xi, f_yi, f_xj, f_yj, f_px, f_py};
    assign {b_flags, b_xi, b_yi, b_xj, b_yj, b_px, b_py} = rd_job;

    ppt_queue #(
        .DATA_WIDTH (JOB_WIDTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (wr_job),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (rd_job)
    );

    ppt_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .xi         (b_xi),
        .yi         (b_yi),
        .xj         (b_xj),
        .yj         (b_yj),
        .px         (b_px),
        .py         (b_py),
        .flags      (b_flags),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res),
        .degenerate (degenerate)
    );

endmodule
